FILE: src/hcbd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbd_pkg
// shared types, codes and helpers for the chunked body decoder
// ---------------------------------------------------------------------------
package hcbd_pkg;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [2:0] KIND_FRAME   = 3'd0;
   localparam logic [2:0] KIND_PAYLOAD = 3'd1;
   localparam logic [2:0] KIND_DONE    = 3'd2;
   localparam logic [2:0] KIND_BAD     = 3'd3;
   localparam logic [2:0] KIND_IDLE    = 3'd4;

   typedef struct packed {
      logic       action;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] payload;
      logic       chunk_end;
   } rsp_type;

   typedef enum logic [8:0] {
      PH_SIZE    = 9'b0_0000_0001,
      PH_SIZE_LF = 9'b0_0000_0010,
      PH_DATA    = 9'b0_0000_0100,
      PH_DATA_CR = 9'b0_0000_1000,
      PH_DATA_LF = 9'b0_0001_0000,
      PH_END_CR  = 9'b0_0010_0000,
      PH_END_LF  = 9'b0_0100_0000,
      PH_DONE    = 9'b0_1000_0000,
      PH_ERROR   = 9'b1_0000_0000
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.value = 4'(b - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

FILE: src/hcbd_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbd_core
// framing state machine and chunk size counter, one body byte per step
// ---------------------------------------------------------------------------
module hcbd_core
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output rsp_type result
);

   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 seen_ff, seen_in;
   logic [SIZE_BITS-1:0] size_dec;
   hex_type              hex;

   assign hex      = hex_decode(item.byte_in);
   assign size_dec = size_ff - SIZE_BITS'(1);

   always_comb begin
      phase_in         = phase_ff;
      size_in          = size_ff;
      seen_in          = seen_ff;
      result.kind      = KIND_FRAME;
      result.payload   = 8'd0;
      result.chunk_end = 1'b0;
      if (item.action) begin
         phase_in = PH_SIZE;
         size_in  = '0;
         seen_in  = 1'b0;
      end else begin
         case (phase_ff)
            PH_SIZE: begin
               if (hex.valid) begin
                  if (size_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                     phase_in    = PH_ERROR;
                     result.kind = KIND_BAD;
                  end else begin
                     size_in = {size_ff[SIZE_BITS-5:0], hex.value};
                     seen_in = 1'b1;
                  end
               end else if (item.byte_in == CHAR_CR && seen_ff) begin
                  phase_in = PH_SIZE_LF;
               end else begin
                  phase_in    = PH_ERROR;
                  result.kind = KIND_BAD;
               end
            end
            PH_SIZE_LF: begin
               if (item.byte_in != CHAR_LF) begin
                  phase_in    = PH_ERROR;
                  result.kind = KIND_BAD;
               end else if (size_ff == '0) begin
                  phase_in = PH_END_CR;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               result.kind    = KIND_PAYLOAD;
               result.payload = item.byte_in;
               size_in        = size_dec;
               if (size_dec == '0) begin
                  result.chunk_end = 1'b1;
                  phase_in         = PH_DATA_CR;
               end
            end
            PH_DATA_CR: begin
               if (item.byte_in == CHAR_CR) begin
                  phase_in = PH_DATA_LF;
               end else begin
                  phase_in    = PH_ERROR;
                  result.kind = KIND_BAD;
               end
            end
            PH_DATA_LF: begin
               if (item.byte_in == CHAR_LF) begin
                  phase_in = PH_SIZE;
                  size_in  = '0;
                  seen_in  = 1'b0;
               end else begin
                  phase_in    = PH_ERROR;
                  result.kind = KIND_BAD;
               end
            end
            PH_END_CR: begin
               if (item.byte_in == CHAR_CR) begin
                  phase_in = PH_END_LF;
               end else begin
                  phase_in    = PH_ERROR;
                  result.kind = KIND_BAD;
               end
            end
            PH_END_LF: begin
               if (item.byte_in == CHAR_LF) begin
                  phase_in    = PH_DONE;
                  result.kind = KIND_DONE;
               end else begin
                  phase_in    = PH_ERROR;
                  result.kind = KIND_BAD;
               end
            end
            PH_DONE: begin
               result.kind = KIND_IDLE;
            end
            default: begin
               phase_in    = PH_ERROR;
               result.kind = KIND_BAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         size_ff  <= '0;
         seen_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         size_ff  <= size_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

FILE: src/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 chunked transfer body decoder, one byte per transaction
// ---------------------------------------------------------------------------
// The decoder takes one body byte (or a restart) per cycle while rsp_ready
// keeps the result register free, and returns exactly one result per input
// transaction, in order. Throughput is one transaction per clock under the
// same condition; a stalled result can hold back new requests. Each result
// passes through the input register and then the result register around the
// framing state machine. Chunk sizes above SIZE_BITS bits and any framing
// deviation report malformed until a restart transaction clears the decoder.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_vld_ff, in_vld_in;
   req_type in_data_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff;
   rsp_type result;
   logic    out_free;
   logic    in_move;
   logic    req_fire;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign in_move   = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign in_vld_in  = req_fire ? 1'b1 : (in_move ? 1'b0 : in_vld_ff);
   assign out_vld_in = in_move ? 1'b1 : (rsp_ready ? 1'b0 : out_vld_ff);

   hcbd_core #(
      .SIZE_BITS(SIZE_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (in_move),
      .item  (in_data_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (in_move) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: src/hcbd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbd_checker
// port level checks on the decoder result channel
// ---------------------------------------------------------------------------
module hcbd_checker
   import hcbd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while waiting");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.kind <= KIND_IDLE)
      else $error("result kind out of range");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_PAYLOAD |->
         rsp_data.payload == 8'd0 && !rsp_data.chunk_end)
      else $error("payload fields set on non-payload result");

   // reset leaves the result channel empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

FILE: tb/http_chunked_body_decoder_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_test
// self-checking bench for the chunked body decoder
// ---------------------------------------------------------------------------
// Feeds chunked bodies byte by byte: a few hand-picked sequences (empty size
// line, sticky malformed, a small complete body, idle after completion,
// oversized chunk size), then random bodies that are mostly well formed,
// some with one corrupted, dropped or restart byte, and some plain noise.
// Each accepted transaction is run through a behavioral decoder and the
// expected result is queued; every returned result is checked field by
// field against the oldest entry. The sender works in bursts with gaps and
// the receiver stalls on its own changing pattern.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_test;
   import hcbd_pkg::*;

   localparam int SIZE_BITS  = 32;
   localparam int ITEM_COUNT = 1700;
   localparam int IDLE_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type byte_stream[$];
   req_type staging[$];
   rsp_type expected_results[$];
   int      errors = 0;

   // behavioral decoder state
   phase_type                dec_phase;
   logic [SIZE_BITS-1:0]     dec_size;
   logic                     dec_digit_seen;
   logic                     dec_last_chunk;

   int burst_left = 1;
   int gap_left = 0;
   int stall_cycle = 0;
   int stall_mode = 0;
   int idle_cycles = 0;

   http_chunked_body_decoder #(
      .SIZE_BITS(SIZE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int hex_digit_value(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   function void clear_decoder();
      dec_phase = PH_SIZE;
      dec_size = '0;
      dec_digit_seen = 1'b0;
      dec_last_chunk = 1'b0;
   endfunction

   function rsp_type decode_step(input req_type r);
      rsp_type res;
      int      digit;
      res.kind = KIND_FRAME;
      res.payload = 8'h00;
      res.chunk_end = 1'b0;
      if (r.action) begin
         clear_decoder();
         return res;
      end
      case (dec_phase)
         PH_SIZE: begin
            digit = hex_digit_value(r.byte_in);
            if (digit >= 0) begin
               if (dec_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                  res.kind = KIND_BAD;
               end else begin
                  dec_size = {dec_size[SIZE_BITS-5:0], 4'(digit)};
                  dec_digit_seen = 1'b1;
               end
            end else if (r.byte_in == CHAR_CR && dec_digit_seen) begin
               dec_phase = PH_SIZE_LF;
            end else begin
               res.kind = KIND_BAD;
            end
         end
         PH_SIZE_LF: begin
            if (r.byte_in != CHAR_LF) begin
               res.kind = KIND_BAD;
            end else if (dec_size == '0) begin
               dec_last_chunk = 1'b1;
               dec_phase = PH_END_CR;
            end else begin
               dec_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            res.kind = KIND_PAYLOAD;
            res.payload = r.byte_in;
            dec_size = dec_size - 1'b1;
            if (dec_size == '0) begin
               res.chunk_end = 1'b1;
               dec_phase = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            if (r.byte_in == CHAR_CR) dec_phase = PH_DATA_LF;
            else res.kind = KIND_BAD;
         end
         PH_DATA_LF: begin
            if (r.byte_in == CHAR_LF) begin
               dec_phase = PH_SIZE;
               dec_size = '0;
               dec_digit_seen = 1'b0;
            end else begin
               res.kind = KIND_BAD;
            end
         end
         PH_END_CR: begin
            if (r.byte_in == CHAR_CR) dec_phase = PH_END_LF;
            else res.kind = KIND_BAD;
         end
         PH_END_LF: begin
            if (r.byte_in == CHAR_LF) begin
               dec_phase = PH_DONE;
               res.kind = KIND_DONE;
            end else begin
               res.kind = KIND_BAD;
            end
         end
         PH_DONE: begin
            res.kind = KIND_IDLE;
         end
         default: begin
            res.kind = KIND_BAD;
         end
      endcase
      if (res.kind == KIND_BAD) dec_phase = PH_ERROR;
      return res;
   endfunction

   // stimulus building
   task automatic stage_byte(input logic [7:0] b);
      staging.insert(staging.size(), '{action: 1'b0, byte_in: b});
   endtask

   task automatic stage_restart();
      staging.insert(staging.size(), '{action: 1'b1, byte_in: 8'($urandom)});
   endtask

   task automatic stage_crlf();
      stage_byte(CHAR_CR);
      stage_byte(CHAR_LF);
   endtask

   task automatic stage_text(input string s);
      for (int i = 0; i < s.len(); i++) stage_byte(s[i]);
   endtask

   task automatic stage_hex(input logic [3:0] v);
      if (v < 4'd10) stage_byte(8'h30 + v);
      else stage_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10);
   endtask

   task automatic stage_size(input logic [31:0] n);
      int top;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) stage_hex(4'd0);
      end
      top = 7;
      while (top > 0 && n[top*4 +: 4] == 4'd0) top--;
      for (int i = top; i >= 0; i--) stage_hex(n[i*4 +: 4]);
   endtask

   task automatic flush_staging();
      foreach (staging[i]) byte_stream.insert(byte_stream.size(), staging[i]);
      staging.delete();
   endtask

   task automatic stage_body(input bit corrupt);
      int n_chunks;
      int size;
      int pos;
      stage_restart();
      n_chunks = $urandom_range(0, 4);
      repeat (n_chunks) begin
         size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
         stage_size(size);
         stage_crlf();
         repeat (size) stage_byte(8'($urandom));
         stage_crlf();
      end
      stage_size(0);
      stage_crlf();
      stage_crlf();
      repeat ($urandom_range(0, 2)) stage_byte(8'($urandom));
      if (corrupt) begin
         pos = $urandom_range(1, staging.size() - 1);
         case ($urandom_range(0, 3))
            0: staging[pos].byte_in = 8'($urandom);
            1: staging.delete(pos);
            2: staging.insert(pos, '{action: 1'b1, byte_in: 8'($urandom)});
            default: staging[pos].byte_in = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
         endcase
      end
   endtask

   task automatic stage_noise();
      string charset;
      charset = "0123456789abcdefABCDEFgG";
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 7))
            0: stage_restart();
            1, 2: stage_byte(8'($urandom));
            3: stage_byte(CHAR_CR);
            4: stage_byte(CHAR_LF);
            default: stage_byte(charset[$urandom_range(0, charset.len() - 1)]);
         endcase
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0 || byte_stream.size() == 0) begin
            req_valid <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            req_valid <= 1'b1;
            req_data <= byte_stream.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 63) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_cycle % 8 != 0);
      endcase
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_decoder();
      end else begin
         if (req_valid && req_ready) begin
            expected_results.insert(expected_results.size(), decode_step(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h", $time, rsp_data);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_data.kind);
                  errors++;
               end
               if (rsp_data.payload !== want.payload) begin
                  $display("%0t: payload expected %h actual %h", $time, want.payload,
                           rsp_data.payload);
                  errors++;
               end
               if (rsp_data.chunk_end !== want.chunk_end) begin
                  $display("%0t: chunk_end expected %b actual %b", $time, want.chunk_end,
                           rsp_data.chunk_end);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      // directed sequences
      stage_byte(CHAR_CR);
      stage_byte(8'h00);
      stage_restart();
      stage_text("1");
      stage_crlf();
      stage_byte(8'hFF);
      stage_crlf();
      stage_text("0");
      stage_crlf();
      stage_crlf();
      stage_byte(8'hFF);
      stage_restart();
      stage_text("fFfFfFfF1");
      flush_staging();

      while (byte_stream.size() < ITEM_COUNT + 25) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) stage_body(1'b0);
         else if (pick < 18) stage_body(1'b1);
         else stage_noise();
         flush_staging();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (byte_stream.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (10) @(posedge clock);

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/hcbd_pkg.sv
src/hcbd_core.sv
src/http_chunked_body_decoder.sv
src/hcbd_checker.sv
tb/http_chunked_body_decoder_test.sv
